// ===== design/ihex_pkg.sv =====
// Shared types, constants and helpers for the Intel HEX record parser.
// No dependencies; the front, queue, back and top-level files refer to this package by scope.
package ihex_pkg;

  // Record framing
  localparam logic [7:0] RecStart     = 8'h3A;  // ':'
  localparam logic [7:0] RecEof       = 8'h01;
  localparam logic [7:0] RecExtSeg    = 8'h02;
  localparam logic [7:0] RecStartSeg  = 8'h03;
  localparam logic [7:0] RecExtLin    = 8'h04;
  localparam logic [7:0] RecStartLin  = 8'h05;
  localparam int unsigned HeaderChars = 9;
  localparam logic [9:0] PosMax       = 10'd1023;
  localparam int unsigned QueueDepth  = 2;

  // Status codes of the end-of-record result
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadChar   = 3'd1;
  localparam logic [2:0] StBadType   = 3'd2;
  localparam logic [2:0] StShortData = 3'd3;
  localparam logic [2:0] StChecksum  = 3'd4;
  localparam logic [2:0] StRecSize   = 3'd5;
  localparam logic [2:0] StUnimpl    = 3'd6;

  // Result kinds
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic [3:0] digit;  // nibble value, zero when not a hex digit
    logic       good;   // character is a hex digit
    logic       colon;  // character is the record start mark
    logic       last;   // last character of the line
    logic [9:0] pos;    // saturating position within the line
  } q_entry_t;

  typedef struct packed {
    logic       good;
    logic [3:0] value;
  } hex_digit_t;

  // Decode one ASCII hex digit, upper or lower case
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.good  = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else begin
      r.good = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/ihex_char_if.sv =====
// Character channel: one ASCII character with its end-of-line flag.
// Depends on nothing; valid/ready handshake, a transfer when both are high.
interface ihex_char_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       line_end;

  modport source (output valid, output text_char, output line_end, input ready);
  modport sink   (input valid, input text_char, input line_end, output ready);
endinterface

// ===== design/ihex_result_if.sv =====
// Result channel: tentative data bytes and end-of-record status items.
// Depends on nothing; valid/ready handshake, a transfer when both are high.
interface ihex_result_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] byte_address;
  logic [7:0]  byte_value;
  logic [7:0]  record_kind;
  logic [7:0]  data_length;
  logic [2:0]  status_code;

  modport source (output valid, output result_kind, output byte_address,
                  output byte_value, output record_kind, output data_length,
                  output status_code, input ready);
  modport sink   (input valid, input result_kind, input byte_address,
                  input byte_value, input record_kind, input data_length,
                  input status_code, output ready);
endinterface

// ===== design/ihex_front.sv =====
// Front end: accepts characters, classifies them and tracks the line position.
// Depends on ihex_pkg and ihex_char_if.
module ihex_front (
  input  logic              clk,
  input  logic              rst,
  ihex_char_if.sink         chars,
  input  logic              q_space,
  output logic              push,
  output ihex_pkg::q_entry_t push_data
);

  logic [9:0]           pos;
  logic [9:0]           pos_next;
  ihex_pkg::hex_digit_t dec;

  assign chars.ready = q_space;
  assign push        = chars.valid && q_space;

  // Classify the incoming character
  always_comb begin
    dec             = ihex_pkg::hex_decode(chars.text_char);
    push_data.digit = dec.value;
    push_data.good  = dec.good;
    push_data.colon = (chars.text_char == ihex_pkg::RecStart);
    push_data.last  = chars.line_end;
    push_data.pos   = pos;
  end

  // Advance the position, saturating; restart on the last character
  always_comb begin
    pos_next = pos;
    if (push) begin
      if (chars.line_end) begin
        pos_next = 10'd0;
      end else if (pos < ihex_pkg::PosMax) begin
        pos_next = pos + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 10'd0;
    end else begin
      pos <= pos_next;
    end
  end

  // A line always restarts at position zero
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    push && chars.line_end |=> pos == 10'd0)
    else $error("line position not cleared after last character");

endmodule

// ===== design/ihex_queue.sv =====
// Short queue between the classifying front and the record back end.
// Depends on ihex_pkg.
module ihex_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ihex_pkg::q_entry_t push_data,
  output logic               space,
  input  logic               pop,
  output logic               avail,
  output ihex_pkg::q_entry_t pop_data
);

  localparam int unsigned PtrW = $clog2(ihex_pkg::QueueDepth);

  ihex_pkg::q_entry_t     slots [ihex_pkg::QueueDepth];
  logic [PtrW-1:0]        wr_ptr;
  logic [PtrW-1:0]        rd_ptr;
  logic [PtrW:0]          fill;

  assign space    = (fill != (PtrW+1)'(ihex_pkg::QueueDepth));
  assign avail    = (fill != '0);
  assign pop_data = slots[rd_ptr];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(ihex_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(ihex_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PtrW+1)'(ihex_pkg::QueueDepth))
    else $error("queue fill beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    push && !pop && !avail |=> avail)
    else $error("transfer into empty queue lost");

endmodule

// ===== design/ihex_back.sv =====
// Back end: assembles bytes, checks the record and drives the result register.
// Depends on ihex_pkg and ihex_result_if.
module ihex_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  ihex_pkg::q_entry_t entry,
  output logic               pop,
  ihex_result_if.source      results
);

  // Per-line record state and the base kept across lines
  logic [3:0]  high_nibble;
  logic [7:0]  count_field;
  logic [15:0] offset_field;
  logic [7:0]  type_field;
  logic [7:0]  running_sum;
  logic        error_latch;
  logic [15:0] address_word;
  logic [31:0] base_address;

  logic [3:0]  high_nibble_next;
  logic [7:0]  count_field_next;
  logic [15:0] offset_field_next;
  logic [7:0]  type_field_next;
  logic [7:0]  running_sum_next;
  logic        error_latch_next;
  logic [15:0] address_word_next;
  logic [31:0] base_address_next;

  logic        out_valid;
  logic        emit_data;
  logic [7:0]  byte_val;
  logic [8:0]  byte_idx;
  logic [7:0]  data_idx;
  logic [10:0] limit;
  logic [10:0] line_len;
  logic        in_range;
  logic        in_data;
  logic [2:0]  status;

  assign pop           = avail && (!out_valid || results.ready);
  assign results.valid = out_valid;

  // Decode the character against the current record state
  always_comb begin
    high_nibble_next  = high_nibble;
    count_field_next  = count_field;
    offset_field_next = offset_field;
    type_field_next   = type_field;
    running_sum_next  = running_sum;
    error_latch_next  = error_latch;
    address_word_next = address_word;
    emit_data         = 1'b0;

    limit    = {2'b00, count_field, 1'b0} + 11'(ihex_pkg::HeaderChars + 1);
    in_range = (entry.pos != 10'd0) && ({1'b0, entry.pos} <= limit);
    byte_val = {high_nibble, entry.digit};
    byte_idx = entry.pos[9:1] - 9'd1;
    in_data  = (byte_idx >= 9'd4) && ({1'b0, byte_idx} < (10'(count_field) + 10'd4));
    data_idx = 8'(byte_idx - 9'd4);

    if (entry.pos == 10'd0) begin
      if (!entry.colon) begin
        error_latch_next = 1'b1;
      end
    end else if (in_range) begin
      if (!entry.good) begin
        error_latch_next = 1'b1;
      end
      if (entry.pos[0]) begin
        high_nibble_next = entry.digit;
      end else begin
        running_sum_next = running_sum + byte_val;
        priority if (byte_idx == 9'd0) begin
          count_field_next = byte_val;
        end else if (byte_idx == 9'd1) begin
          offset_field_next = {byte_val, 8'h00};
        end else if (byte_idx == 9'd2) begin
          offset_field_next = {offset_field[15:8], byte_val};
        end else if (byte_idx == 9'd3) begin
          type_field_next = byte_val;
        end else if (in_data) begin
          if (data_idx == 8'd0) begin
            address_word_next = {byte_val, 8'h00};
          end else if (data_idx == 8'd1) begin
            address_word_next = {address_word[15:8], byte_val};
          end
          emit_data = (type_field == 8'h00) && !entry.last;
        end else begin
          // checksum byte: only summed
          emit_data = 1'b0;
        end
      end
    end
  end

  // Judge the finished record
  always_comb begin
    line_len          = {1'b0, entry.pos} + 11'd1;
    base_address_next = base_address;
    priority if (error_latch_next ||
                 line_len < 11'(ihex_pkg::HeaderChars + 2)) begin
      status = ihex_pkg::StBadChar;
    end else if (type_field_next > ihex_pkg::RecStartLin) begin
      status = ihex_pkg::StBadType;
    end else if (line_len < ({2'b00, count_field_next, 1'b0} +
                             11'(ihex_pkg::HeaderChars + 2))) begin
      status = ihex_pkg::StShortData;
    end else if (running_sum_next != 8'h00) begin
      status = ihex_pkg::StChecksum;
    end else if (type_field_next == ihex_pkg::RecExtSeg ||
                 type_field_next == ihex_pkg::RecExtLin) begin
      status = (count_field_next < 8'd2) ? ihex_pkg::StRecSize : ihex_pkg::StOk;
    end else if (type_field_next == ihex_pkg::RecStartSeg ||
                 type_field_next == ihex_pkg::RecStartLin) begin
      status = (count_field_next < 8'd4) ? ihex_pkg::StRecSize : ihex_pkg::StUnimpl;
    end else begin
      status = ihex_pkg::StOk;
    end
    if (status == ihex_pkg::StOk && type_field_next == ihex_pkg::RecExtSeg) begin
      base_address_next = {12'h000, address_word_next, 4'h0};
    end else if (status == ihex_pkg::StOk && type_field_next == ihex_pkg::RecExtLin) begin
      base_address_next = {address_word_next, 16'h0000};
    end
  end

  // Update record state; clear per-line state after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      high_nibble  <= '0;
      count_field  <= '0;
      offset_field <= '0;
      type_field   <= '0;
      running_sum  <= '0;
      error_latch  <= 1'b0;
      address_word <= '0;
      base_address <= '0;
    end else if (pop) begin
      if (entry.last) begin
        high_nibble  <= '0;
        count_field  <= '0;
        offset_field <= '0;
        type_field   <= '0;
        running_sum  <= '0;
        error_latch  <= 1'b0;
        address_word <= '0;
        base_address <= base_address_next;
      end else begin
        high_nibble  <= high_nibble_next;
        count_field  <= count_field_next;
        offset_field <= offset_field_next;
        type_field   <= type_field_next;
        running_sum  <= running_sum_next;
        error_latch  <= error_latch_next;
        address_word <= address_word_next;
      end
    end
  end

  // Output register: load on a producing transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= entry.last || emit_data;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.record_kind <= type_field_next;
      results.data_length <= count_field_next;
      if (entry.last) begin
        results.result_kind  <= ihex_pkg::KindStatus;
        results.byte_address <= 32'h0;
        results.byte_value   <= 8'h00;
        results.status_code  <= status;
      end else begin
        results.result_kind  <= ihex_pkg::KindData;
        results.byte_address <= base_address + {16'h0000, offset_field} +
                                {24'h000000, data_idx};
        results.byte_value   <= byte_val;
        results.status_code  <= ihex_pkg::StOk;
      end
    end
  end

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    pop && entry.last |=> out_valid && results.result_kind == ihex_pkg::KindStatus)
    else $error("last character did not yield a status result");

  a_data_mid_line: assert property (@(posedge clk) disable iff (rst)
    pop && !entry.last |=> !out_valid || results.result_kind == ihex_pkg::KindData)
    else $error("status result before the end of the line");

endmodule

// ===== design/intel_hex_record_parser.sv =====
// Intel HEX record parser. Takes one character per cycle on the chars channel while the
// queue has space, and gives at most one result per character on the results channel: a
// tentative data byte with its absolute address for type 00 records, and a status item on
// the character flagged as the last of its line. Commit data only when that status is ok.
// The front classifies each character and pushes it into the two-entry queue; the back
// takes it from the queue, updates the record state and loads the result register at the
// edge it is taken, so a character passes a queue slot and then the result register
// before its result is offered. The sustained rate is one character per cycle while
// results are taken. A result left waiting holds the queue; once it holds two characters
// the input stalls, and after the result is taken the back pops the queue and the input
// resumes once the queue has space again.
module intel_hex_record_parser (
  input  logic          clk,
  input  logic          rst,
  ihex_char_if.sink     chars,
  ihex_result_if.source results
);

  logic               push;
  logic               pop;
  logic               q_space;
  logic               q_avail;
  ihex_pkg::q_entry_t push_data;
  ihex_pkg::q_entry_t pop_data;

  ihex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .q_space   (q_space),
    .push      (push),
    .push_data (push_data)
  );

  ihex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (q_space),
    .pop       (pop),
    .avail     (q_avail),
    .pop_data  (pop_data)
  );

  ihex_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (q_avail),
    .entry   (pop_data),
    .pop     (pop),
    .results (results)
  );

endmodule
